// ----- src/ssa_pkg.sv -----
// Shared types and constants for the swap slot allocator.
// No dependencies; every other file in src imports this package.
package ssa_pkg;

   // Geometry of the swap area
   localparam int SLOTS           = 16;
   localparam int BLOCKS_PER_SLOT = 120;
   localparam int MAP_DEPTH       = 3 * SLOTS;
   localparam int LARGE_SPAN      = SLOTS * BLOCKS_PER_SLOT;

   // Field and bus widths
   localparam int ADDR_W  = 25;
   localparam int BASE_W  = 24;
   localparam int FUNC_W  = 2;
   localparam int STAT_W  = 2;
   localparam int IDX_W   = $clog2(MAP_DEPTH);
   localparam int TDATA_W = 32;
   localparam int CSR_W   = 24;

   // Request kinds
   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC_LARGE  = 2'd0,
      FUNC_ALLOC_SINGLE = 2'd1,
      FUNC_FREE         = 2'd2,
      FUNC_NONE         = 2'd3
   } func_type;

   // Result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // Free-address decode result
   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] idx;
   } dec_type;

   // Command into the bitmap
   typedef struct packed {
      logic             apply;
      func_type         func;
      logic             free_hit;
      logic [IDX_W-1:0] free_idx;
   } bmp_cmd_type;

   // Lowest free entries reported by the bitmap
   typedef struct packed {
      logic             large_ok;
      logic [IDX_W-1:0] large_idx;
      logic             single_ok;
      logic [IDX_W-1:0] single_idx;
   } bmp_find_type;

endpackage

// ----- src/ssa_addr_decode.sv -----
// Maps a returned disk address back to its usage map entry.
// Depends on ssa_pkg for geometry constants and dec_type.
module ssa_addr_decode
   import ssa_pkg::*;
(
   input  logic [ADDR_W-1:0] addr,
   input  logic [BASE_W-1:0] base,
   output dec_type           dec
);

   localparam logic [ADDR_W-1:0] LARGE_SPAN_A = ADDR_W'(LARGE_SPAN);
   localparam logic [ADDR_W-1:0] MAP_DEPTH_A  = ADDR_W'(MAP_DEPTH);

   logic [ADDR_W-1:0] base_ext;
   logic [ADDR_W-1:0] off;
   logic [ADDR_W-1:0] diff;
   logic [IDX_W-1:0]  slot_q;

   assign base_ext = ADDR_W'(base);
   assign off      = addr - base_ext;
   assign diff     = off - LARGE_SPAN_A;

   // Quotient by the slot size: highest slot boundary at or below the offset
   always_comb begin
      slot_q = '0;
      for (int k = 1; k < SLOTS; k++) begin
         if (off >= ADDR_W'(k * BLOCKS_PER_SLOT)) begin
            slot_q = IDX_W'(k);
         end
      end
   end

   // Pick the entry and flag anything below base or beyond the map
   always_comb begin
      if (addr < base_ext) begin
         dec.hit = 1'b0;
         dec.idx = '0;
      end else if (off < LARGE_SPAN_A) begin
         dec.hit = 1'b1;
         dec.idx = slot_q;
      end else begin
         dec.hit = (diff < MAP_DEPTH_A);
         dec.idx = diff[IDX_W-1:0];
      end
   end

endmodule

// ----- src/ssa_bitmap.sv -----
// Usage bitmap with lowest-free search for both regions and set/clear update.
// Depends on ssa_pkg for map depth and the command/find structs.
module ssa_bitmap
   import ssa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  bmp_cmd_type  cmd,
   output bmp_find_type find
);

   logic [MAP_DEPTH-1:0] slot_used_ff;
   logic [MAP_DEPTH-1:0] slot_used_in;

   // Lowest free large slot
   always_comb begin
      find.large_ok  = 1'b0;
      find.large_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!slot_used_ff[i]) begin
            find.large_ok  = 1'b1;
            find.large_idx = IDX_W'(i);
         end
      end
   end

   // Lowest free single block
   always_comb begin
      find.single_ok  = 1'b0;
      find.single_idx = '0;
      for (int i = MAP_DEPTH - 1; i >= SLOTS; i--) begin
         if (!slot_used_ff[i]) begin
            find.single_ok  = 1'b1;
            find.single_idx = IDX_W'(i);
         end
      end
   end

   // Mark or release the entry chosen by the request being retired
   always_comb begin
      slot_used_in = slot_used_ff;
      if (cmd.apply) begin
         unique case (cmd.func)
            FUNC_ALLOC_LARGE: begin
               if (find.large_ok) slot_used_in[find.large_idx] = 1'b1;
            end
            FUNC_ALLOC_SINGLE: begin
               if (find.single_ok) slot_used_in[find.single_idx] = 1'b1;
            end
            FUNC_FREE: begin
               if (cmd.free_hit) slot_used_in[cmd.free_idx] = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_used_ff <= '0;
      end else begin
         slot_used_ff <= slot_used_in;
      end
   end

endmodule

// ----- src/swap_slot_allocator_top.sv -----
// Top level of the swap slot allocator: request register, result register, csr.
// Depends on ssa_pkg, ssa_addr_decode and ssa_bitmap.
//
//   channel  ports                         direction  carries
//   req      req_tvalid/tready/tdata/tuser in         tdata: free_address, tuser: func
//   rsp      rsp_tvalid/tready/tdata/tuser out        tdata: block_address, tuser: status
//   csr      csr_valid/csr_ready/csr_data  in         swap_base
//
// One request per cycle is sustained while rsp_tready holds high; each moves
// through the request register, then the result register. The bitmap search and
// update for a request happen as it moves into the result register, so the
// next request always sees the updated map. Reset frees every entry and
// clears swap_base. A stalled result holds the result register and, once the
// request register is also full, req_tready drops.
module swap_slot_allocator_top
   import ssa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // [24:0] free_address, rest zero
   input  logic [FUNC_W-1:0]  req_tuser,   // [1:0] func
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // [24:0] block_address, rest zero
   output logic [STAT_W-1:0]  rsp_tuser,   // [1:0] status
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_W-1:0]   csr_data     // [23:0] swap_base
);

   localparam logic [ADDR_W-1:0] LARGE_SPAN_A = ADDR_W'(LARGE_SPAN);
   localparam logic [ADDR_W-1:0] BPS_A        = ADDR_W'(BLOCKS_PER_SLOT);

   logic [BASE_W-1:0] base_ff;
   logic              req_valid_ff;
   func_type          req_func_ff;
   logic [ADDR_W-1:0] req_addr_ff;
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   status_type        rsp_status_ff;
   logic [ADDR_W-1:0] rsp_addr_in;
   status_type        rsp_status_in;

   logic              advance;
   logic              req_xfer;
   dec_type           dec;
   bmp_cmd_type       cmd;
   bmp_find_type      find;

   // Handshake control
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_valid) begin
         base_ff <= BASE_W'(csr_data);
      end
   end

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_func_ff <= func_type'(req_tuser);
         req_addr_ff <= req_tdata[ADDR_W-1:0];
      end
   end

   ssa_addr_decode u_decode (
      .addr (req_addr_ff),
      .base (base_ff),
      .dec  (dec)
   );

   assign cmd.apply    = advance;
   assign cmd.func     = req_func_ff;
   assign cmd.free_hit = dec.hit;
   assign cmd.free_idx = dec.idx;

   ssa_bitmap u_bitmap (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .find  (find)
   );

   // Form the disk address and status of the request
   always_comb begin
      rsp_addr_in   = '0;
      rsp_status_in = ST_OK;
      case (req_func_ff)
         FUNC_ALLOC_LARGE: begin
            if (find.large_ok) begin
               rsp_addr_in = ADDR_W'(base_ff) + ADDR_W'(find.large_idx) * BPS_A;
            end else begin
               rsp_status_in = ST_FULL;
            end
         end
         FUNC_ALLOC_SINGLE: begin
            if (find.single_ok) begin
               rsp_addr_in = ADDR_W'(base_ff) + LARGE_SPAN_A + ADDR_W'(find.single_idx);
            end else begin
               rsp_status_in = ST_FULL;
            end
         end
         FUNC_FREE: begin
            if (!dec.hit) rsp_status_in = ST_RANGE;
         end
         default: begin
         end
      endcase
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_addr_ff   <= rsp_addr_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_addr_ff);
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- verif/swap_slot_allocator_top_tb.sv -----
// Self-checking testbench for swap_slot_allocator_top: directed and random
// allocate/free traffic checked against a bitmap predictor of its own.
// Depends on ssa_pkg and the swap slot allocator RTL in src.
`timescale 1ns / 100ps

module swap_slot_allocator_top_tb;
   import ssa_pkg::*;

   localparam int IDLE_LIMIT       = 2000;
   localparam int HOLDOFF_CYCLES   = 300;
   localparam int RANDOM_PER_PHASE = 280;
   localparam int NUM_PHASES       = 6;

   typedef struct {
      func_type          func;
      logic [ADDR_W-1:0] addr;
   } slot_request;

   typedef struct {
      logic [ADDR_W-1:0] blk;
      status_type        st;
   } slot_grant;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata  = '0;   // [24:0] free_address, rest zero
   logic [FUNC_W-1:0]  req_tuser  = '0;   // [1:0] func
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;         // [24:0] block_address, rest zero
   logic [STAT_W-1:0]  rsp_tuser;         // [1:0] status
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [CSR_W-1:0]   csr_data   = '0;   // [23:0] swap_base

   // Predictor state: usage bitmap and the swap base in force
   logic [MAP_DEPTH-1:0] slot_map = '0;
   logic [BASE_W-1:0]    base_reg = '0;

   slot_request pending_requests[$];
   slot_grant   awaited_grants[$];

   int mismatches  = 0;
   int grants_seen = 0;
   int idle_cycles = 0;
   logic [BASE_W-1:0] phase_bases[NUM_PHASES];

   swap_slot_allocator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one request to the bitmap and work out the address and status it earns
   task automatic allocate_or_free(input func_type f, input logic [ADDR_W-1:0] a,
                                   output logic [ADDR_W-1:0] blk, output status_type st);
      int i;
      int hit;
      logic [31:0] sum;
      logic [31:0] off;
      logic [31:0] ent;
      blk = '0;
      st  = ST_OK;
      hit = -1;
      case (f)
         FUNC_ALLOC_LARGE: begin
            for (i = SLOTS - 1; i >= 0; i--)
               if (!slot_map[i]) hit = i;
            if (hit < 0) begin
               st = ST_FULL;
            end else begin
               slot_map[hit] = 1'b1;
               sum = {8'b0, base_reg} + hit * BLOCKS_PER_SLOT;
               blk = sum[ADDR_W-1:0];
            end
         end
         FUNC_ALLOC_SINGLE: begin
            for (i = MAP_DEPTH - 1; i >= SLOTS; i--)
               if (!slot_map[i]) hit = i;
            if (hit < 0) begin
               st = ST_FULL;
            end else begin
               slot_map[hit] = 1'b1;
               sum = {8'b0, base_reg} + LARGE_SPAN + hit;
               blk = sum[ADDR_W-1:0];
            end
         end
         FUNC_FREE: begin
            if ({7'b0, a} < {8'b0, base_reg}) begin
               st = ST_RANGE;
            end else begin
               off = {7'b0, a} - {8'b0, base_reg};
               // any block of a large slot frees the whole slot
               if (off < LARGE_SPAN) ent = off / BLOCKS_PER_SLOT;
               else                  ent = off - LARGE_SPAN;
               if (ent < MAP_DEPTH) slot_map[ent] = 1'b0;
               else                 st = ST_RANGE;
            end
         end
         default: ;
      endcase
   endtask

   task automatic add_request(input func_type f, input logic [ADDR_W-1:0] a);
      slot_request r;
      r.func = f;
      r.addr = a;
      pending_requests.push_back(r);
   endtask

   // An address inside a mapped entry at the current base
   function automatic logic [ADDR_W-1:0] entry_address(input int entry);
      logic [31:0] s;
      if (entry < SLOTS)
         s = {8'b0, base_reg} + entry * BLOCKS_PER_SLOT
             + $urandom_range(0, BLOCKS_PER_SLOT - 1);
      else
         s = {8'b0, base_reg} + LARGE_SPAN + entry;
      return s[ADDR_W-1:0];
   endfunction

   // Addresses at the borders of the map, plus wholly random ones
   function automatic logic [ADDR_W-1:0] boundary_address();
      logic [31:0] b;
      b = {8'b0, base_reg};
      case ($urandom_range(0, 9))
         0: b = b - 1;
         1: ;
         2: b = b + LARGE_SPAN - 1;
         3: b = b + LARGE_SPAN + $urandom_range(0, SLOTS - 1);
         4: b = b + LARGE_SPAN + MAP_DEPTH - 1;
         5: b = b + LARGE_SPAN + MAP_DEPTH + $urandom_range(0, 3);
         6: b = 32'h01FF_FFFF;
         7: b = 32'h0;
         default: b = $urandom;
      endcase
      return b[ADDR_W-1:0];
   endfunction

   // Random traffic that swings between filling and draining the map
   task automatic random_mix(input int n);
      int k;
      int r;
      int tide_left;
      bit filling;
      tide_left = 0;
      filling   = 1'b0;
      for (k = 0; k < n; k++) begin
         if (tide_left == 0) begin
            filling   = !filling;
            tide_left = $urandom_range(30, 120);
         end
         tide_left--;
         r = $urandom_range(0, 99);
         if (r < 10) begin
            add_request(func_type'($urandom_range(0, 3)), boundary_address());
         end else if ((filling && r < 75) || (!filling && r < 30)) begin
            add_request($urandom_range(0, 1) ? FUNC_ALLOC_LARGE : FUNC_ALLOC_SINGLE,
                        ADDR_W'($urandom));
         end else begin
            add_request(FUNC_FREE, entry_address($urandom_range(0, MAP_DEPTH - 1)));
         end
      end
   endtask

   // Write swap_base through the csr channel; only called while the block is idle
   task automatic write_swap_base(input logic [BASE_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      base_reg = v;
      @(negedge clock);
   endtask

   // Wait until every request has been sent and answered
   task automatic settle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || awaited_grants.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Request driver: bursts of random length with random gaps between them
   always @(posedge clock) begin : drive_requests
      slot_request cur;
      slot_grant   g;
      static int burst_left = 8;
      static int gap_left   = 0;
      if (!reset) begin
         // retire the accepted transfer and predict its result
         if (req_tvalid && req_tready) begin
            cur = pending_requests.pop_front();
            allocate_or_free(cur.func, cur.addr, g.blk, g.st);
            awaited_grants.push_back(g);
            burst_left--;
            if (burst_left <= 0) begin
               if ($urandom_range(0, 7) == 0) begin
                  burst_left = $urandom_range(50, 150);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
               end
            end
         end
         // hold an offered item until it is taken
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {{(TDATA_W - ADDR_W){1'b0}}, pending_requests[0].addr};
               req_tuser  <= pending_requests[0].func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver stall pattern
   always @(posedge clock) begin : check_grants
      slot_grant exp;
      static int holdoff_left = 0;
      static int cyc          = 0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            grants_seen++;
            if (awaited_grants.size() == 0) begin
               $error("unexpected result: block_address %0d status %0d",
                      rsp_tdata[ADDR_W-1:0], rsp_tuser);
               mismatches++;
            end else begin
               exp = awaited_grants.pop_front();
               if (rsp_tdata[ADDR_W-1:0] !== exp.blk) begin
                  $error("block_address: expected %0d, got %0d",
                         exp.blk, rsp_tdata[ADDR_W-1:0]);
                  mismatches++;
               end
               if (rsp_tuser !== exp.st) begin
                  $error("status: expected %0d, got %0d", exp.st, rsp_tuser);
                  mismatches++;
               end
            end
            // back up the block twice during the run
            if (grants_seen == 400 || grants_seen == 1200)
               holdoff_left = HOLDOFF_CYCLES;
         end
         cyc++;
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (cyc[7:6])
               2'd0: rsp_tready <= 1'b1;
               2'd1: rsp_tready <= $urandom_range(0, 1);
               2'd2: rsp_tready <= (cyc[1:0] == 2'd0);
               default: rsp_tready <= $urandom_range(0, 6) != 0;
            endcase
         end
      end
   end

   // Watchdog: stop a run that has gone quiet
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("swap_slot_allocator_top_tb: errors");
         $finish;
      end
   end

   initial begin
      int i;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: fill the large region past full, then the free corner cases
      write_swap_base(24'd2000);
      add_request(FUNC_ALLOC_LARGE, '0);
      for (i = 1; i < SLOTS + 1; i++)
         add_request(FUNC_ALLOC_LARGE, ADDR_W'($urandom));
      add_request(FUNC_FREE, entry_address(1) | 25'd0);
      add_request(FUNC_FREE, 25'(base_reg + LARGE_SPAN));
      add_request(FUNC_FREE, 25'(base_reg + LARGE_SPAN));
      add_request(FUNC_FREE, 25'(base_reg - 1));
      add_request(FUNC_FREE, 25'(base_reg + LARGE_SPAN + MAP_DEPTH));
      add_request(FUNC_FREE, 25'h1FF_FFFF);
      add_request(FUNC_ALLOC_SINGLE, 25'h0AA_AAAA);
      add_request(FUNC_FREE, 25'(base_reg + LARGE_SPAN + MAP_DEPTH - 1));
      add_request(FUNC_NONE, 25'h1FF_FFFF);
      settle();

      // Random phases across a spread of bases, extremes included
      phase_bases[0] = 24'h00_0000;
      phase_bases[1] = 24'hFF_FFFF;
      phase_bases[2] = 24'h00_0001;
      phase_bases[3] = BASE_W'($urandom);
      phase_bases[4] = 24'hFF_F000 | BASE_W'($urandom_range(0, 4095));
      phase_bases[5] = BASE_W'($urandom_range(0, 65535));
      for (i = 0; i < NUM_PHASES; i++) begin
         write_swap_base(phase_bases[i]);
         random_mix(RANDOM_PER_PHASE);
         settle();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("swap_slot_allocator_top_tb: clean");
      else
         $display("swap_slot_allocator_top_tb: errors");
      $finish;
   end

endmodule

// ----- sim.f -----
src/ssa_pkg.sv
src/ssa_addr_decode.sv
src/ssa_bitmap.sv
src/swap_slot_allocator_top.sv
verif/swap_slot_allocator_top_tb.sv
